// ----- sv/tas_pkg.sv -----
`default_nettype none
package tas_pkg;

	localparam int FRAC_BITS = 8;
	// quotient and root width
	localparam int QW = 16 + FRAC_BITS;
	// magnitude of r2^2 - r1^2 - d^2
	localparam int CMW = 34;
	localparam int NUMW = CMW + FRAC_BITS + 1;
	localparam int DENW = 17;
	localparam int RW = 2 * QW;
	localparam int XW = 26;
	localparam int YW = 24;
	localparam int XIW = 17 + FRAC_BITS + 2;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam int LATENCY = 2 * QW + 6;
	localparam logic signed [15:0] OFFSET_RST = 16'sd620;

	typedef enum logic [1:0] {
		ST_SAME    = 2'd0,
		ST_NONE    = 2'd1,
		ST_TANGENT = 2'd2,
		ST_TWO     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] anchor_one_pos;
		logic signed [15:0] anchor_two_pos;
		logic [15:0]        range_one;
		logic [15:0]        range_two;
	} in_t;

	typedef struct packed {
		logic signed [XW-1:0] pos_x;
		logic [YW-1:0]        pos_y;
		logic [1:0]           solve_status;
	} out_t;

	typedef struct packed {
		logic                neg;
		logic [NUMW-1:0]     num;
		logic [DENW-1:0]     den;
		logic signed [16:0]  c1;
		logic [15:0]         r1;
		status_t             st;
	} qe_t;

endpackage
`default_nettype wire

// ----- sv/tas_front.sv -----
`default_nettype none
module tas_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire tas_pkg::in_t        req,
	input  wire logic signed [15:0]  offset,
	output logic                     push,
	output tas_pkg::qe_t             ent
);
	import tas_pkg::*;

	logic signed [16:0] c1_d, c2_d, dd_d;
	logic [16:0]        ndd_d, sum_d;
	logic [15:0]        dabs_d, diff_d;
	status_t            st_d;

	logic               vld_s1, dneg_s1;
	logic signed [16:0] c1_s1;
	logic [15:0]        dabs_s1, r1_s1, r2_s1;
	status_t            st_s1;

	logic               vld_s2, dneg_s2;
	logic signed [16:0] c1_s2;
	logic [15:0]        dabs_s2, r1_s2;
	logic [31:0]        sq1_s2, sq2_s2, sqd_s2;
	status_t            st_s2;

	logic signed [CMW:0] c_d;
	logic [CMW:0]        nc_d;
	logic [CMW-1:0]      cm_d;

	always_comb begin
		c1_d = {req.anchor_one_pos[15], req.anchor_one_pos} - {offset[15], offset};
		c2_d = {req.anchor_two_pos[15], req.anchor_two_pos} - {offset[15], offset};
		dd_d = c1_d - c2_d;
		ndd_d = -dd_d;
		dabs_d = dd_d[16] ? ndd_d[15:0] : dd_d[15:0];
		sum_d = {1'b0, req.range_one} + {1'b0, req.range_two};
		diff_d = (req.range_one > req.range_two) ? req.range_one - req.range_two
			: req.range_two - req.range_one;
		if (dd_d == 17'sd0 && req.range_one == req.range_two) begin
			st_d = ST_SAME;
		end else if ({1'b0, dabs_d} > sum_d || dabs_d < diff_d) begin
			st_d = ST_NONE;
		end else if ({1'b0, dabs_d} == sum_d || dabs_d == diff_d) begin
			st_d = ST_TANGENT;
		end else begin
			st_d = ST_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		c1_s1   <= c1_d;
		dneg_s1 <= dd_d[16];
		dabs_s1 <= dabs_d;
		r1_s1   <= req.range_one;
		r2_s1   <= req.range_two;
		st_s1   <= st_d;

		sq1_s2  <= r1_s1 * r1_s1;
		sq2_s2  <= r2_s1 * r2_s1;
		sqd_s2  <= dabs_s1 * dabs_s1;
		c1_s2   <= c1_s1;
		dneg_s2 <= dneg_s1;
		dabs_s2 <= dabs_s1;
		r1_s2   <= r1_s1;
		st_s2   <= st_s1;
	end

	always_comb begin
		c_d = {{(CMW-31){1'b0}}, sq2_s2} - {{(CMW-31){1'b0}}, sq1_s2}
			- {{(CMW-31){1'b0}}, sqd_s2};
		nc_d = -c_d;
		cm_d = c_d[CMW] ? nc_d[CMW-1:0] : c_d[CMW-1:0];
		ent.neg = c_d[CMW] ^ dneg_s2;
		ent.num = ({{(NUMW-CMW){1'b0}}, cm_d} << FRAC_BITS)
			+ {{(NUMW-16){1'b0}}, dabs_s2};
		ent.den = {dabs_s2, 1'b0};
		ent.c1 = c1_s2;
		ent.r1 = r1_s2;
		ent.st = st_s2;
		push = vld_s2;
	end

endmodule
`default_nettype wire

// ----- sv/tas_queue.sv -----
`default_nettype none
module tas_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tas_pkg::qe_t  din,
	output logic               pop,
	output tas_pkg::qe_t       dout,
	output logic               busy
);
	import tas_pkg::*;

	qe_t              entries_q [QDEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QAW:0]     cnt_q;

	// back end drains one request per cycle, never stalls
	assign pop  = (cnt_q != '0);
	assign dout = entries_q[rd_q];
	// two requests may still be in the front stages
	assign busy = (cnt_q > (QAW+1)'(QDEPTH - 3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

// ----- sv/tas_back.sv -----
`default_nettype none
module tas_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_in,
	input  wire tas_pkg::qe_t  ent,
	output logic               done,
	output tas_pkg::out_t      res
);
	import tas_pkg::*;

	typedef struct packed {
		logic               vld;
		logic [NUMW-1:0]    rem;
		logic [DENW-1:0]    den;
		logic [QW-1:0]      q;
		logic               neg;
		logic signed [16:0] c1;
		logic [15:0]        r1;
		status_t            st;
	} dv_t;

	typedef struct packed {
		logic          vld;
		logic [XW-1:0] x;
		logic [RW-1:0] rr;
		logic [RW-1:0] qq;
		status_t       st;
	} sq_t;

	typedef struct packed {
		logic          vld;
		logic [RW-1:0] rem;
		logic [QW-1:0] res;
		logic [XW-1:0] x;
		status_t       st;
	} rt_t;

	localparam logic signed [XIW-1:0] XHI = XIW'((2**(XW-1)) - 1);
	localparam logic signed [XIW-1:0] XLO = XIW'(-(2**(XW-1)));
	localparam logic [QW+YW-1:0] YSAT = (QW+YW)'((2**YW) - 1);

	dv_t dv_in;
	dv_t dv_s [1:QW];
	sq_t sq_s1;
	rt_t rt_s [0:QW];
	logic done_q;
	out_t res_q;

	always_comb begin
		dv_in.vld = vld_in;
		dv_in.rem = ent.num;
		dv_in.den = ent.den;
		dv_in.q   = '0;
		dv_in.neg = ent.neg;
		dv_in.c1  = ent.c1;
		dv_in.r1  = ent.r1;
		dv_in.st  = ent.st;
	end

	// restoring divider, one quotient bit per stage, msb first
	genvar k;
	for (k = 1; k <= QW; k++) begin : g_div
		dv_t prv, nxt;
		logic [NUMW:0] trial;
		if (k == 1) begin : g_first
			assign prv = dv_in;
		end else begin : g_rest
			assign prv = dv_s[k-1];
		end
		always_comb begin
			nxt = prv;
			trial = {1'b0, prv.rem}
				- ({{(NUMW+1-DENW){1'b0}}, prv.den} << (QW - k));
			if (!trial[NUMW]) begin
				nxt.rem = trial[NUMW-1:0];
				nxt.q[QW-k] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= '0;
			end else begin
				dv_s[k] <= nxt;
			end
		end
	end

	// signed offset, x, and the clamped squares for the root
	logic [QW:0]           qext, qsig;
	logic signed [XIW-1:0] xs;
	logic [XW-1:0]         xc;
	logic [QW-1:0]         rf, qc;

	always_comb begin
		qext = {1'b0, dv_s[QW].q};
		qsig = dv_s[QW].neg ? -qext : qext;
		xs = ({{(XIW-17){dv_s[QW].c1[16]}}, dv_s[QW].c1} << FRAC_BITS)
			+ {{(XIW-QW-1){qsig[QW]}}, qsig};
		if (xs > XHI) begin
			xc = XHI[XW-1:0];
		end else if (xs < XLO) begin
			xc = XLO[XW-1:0];
		end else begin
			xc = xs[XW-1:0];
		end
		rf = QW'(dv_s[QW].r1) << FRAC_BITS;
		qc = (dv_s[QW].q > rf) ? rf : dv_s[QW].q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_s1 <= '0;
			rt_s[0] <= '0;
		end else begin
			sq_s1.vld <= dv_s[QW].vld;
			sq_s1.x   <= xc;
			sq_s1.rr  <= RW'(rf) * RW'(rf);
			sq_s1.qq  <= RW'(qc) * RW'(qc);
			sq_s1.st  <= dv_s[QW].st;
			rt_s[0].vld <= sq_s1.vld;
			rt_s[0].rem <= sq_s1.rr - sq_s1.qq;
			rt_s[0].res <= '0;
			rt_s[0].x   <= sq_s1.x;
			rt_s[0].st  <= sq_s1.st;
		end
	end

	// digit-by-digit square root, one result bit per stage
	for (k = 1; k <= QW; k++) begin : g_root
		rt_t nxt;
		logic [RW:0] t;
		always_comb begin
			nxt = rt_s[k-1];
			t = ({1'b0, RW'(rt_s[k-1].res)} << (QW - k + 1))
				+ ((RW+1)'(1) << (2 * (QW - k)));
			if ({1'b0, rt_s[k-1].rem} >= t) begin
				nxt.rem = rt_s[k-1].rem - t[RW-1:0];
				nxt.res[QW-k] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_s[k] <= '0;
			end else begin
				rt_s[k] <= nxt;
			end
		end
	end

	logic [QW+YW-1:0] ye;
	logic [YW-1:0]    yc;
	logic             zero;

	always_comb begin
		ye = (QW+YW)'(rt_s[QW].res);
		yc = (ye > YSAT) ? YSAT[YW-1:0] : ye[YW-1:0];
		zero = (rt_s[QW].st == ST_SAME) || (rt_s[QW].st == ST_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rt_s[QW].vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.pos_x        <= zero ? '0 : rt_s[QW].x;
		res_q.pos_y        <= zero ? '0 : yc;
		res_q.solve_status <= rt_s[QW].st;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ----- sv/two_anchor_position_solver.sv -----
// two-anchor position solver: intersects the two range circles centred at
// anchor position minus anchor_offset and returns x, y (y >= 0) in fixed point
// with FRAC_BITS fraction bits plus a status. a new request is taken every
// cycle (start while busy is low); each result appears on res with done high
// for one cycle. the divider and square-root pipelines each resolve one bit
// per stage. results cannot be held off. anchor_offset is to be written
// through cfg_valid/cfg_ready only while no request is in flight; the block
// itself does not enforce this. it applies to requests taken afterwards.
`default_nettype none
module two_anchor_position_solver (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire tas_pkg::in_t        req,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic signed [15:0]  cfg_data,
	output logic                     done,
	output tas_pkg::out_t            res
);
	import tas_pkg::*;

	logic signed [15:0] offset_q;
	logic               acc, push, pop;
	qe_t                ent_in, ent_out;

	assign cfg_ready = 1'b1;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	tas_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.req    (req),
		.offset (offset_q),
		.push   (push),
		.ent    (ent_in)
	);

	tas_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (ent_in),
		.pop    (pop),
		.dout   (ent_out),
		.busy   (busy)
	);

	tas_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (pop),
		.ent    (ent_out),
		.done   (done),
		.res    (res)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LATENCY done)
		else $error("result missing at fixed latency");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue backed up");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.solve_status == ST_SAME || res.solve_status == ST_NONE)
		|-> res.pos_x == '0 && res.pos_y == '0)
		else $error("nonzero position without an intersection");

endmodule
`default_nettype wire

// ----- tb/sv/two_anchor_position_solver_chk.sv -----
`timescale 1ns / 100ps
`default_nettype none
module two_anchor_position_solver_chk (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire tas_pkg::in_t  req,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic [15:0]   cfg_data,
	input  wire logic          done,
	input  wire tas_pkg::out_t res,
	output int                 fail_count,
	output int                 pending
);
	import tas_pkg::*;

	logic signed [15:0] offset_q;
	out_t fix_q[$];

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic out_t solve_fix(input in_t a, input logic signed [15:0] off);
		longint c1, c2, r1, r2, dd, dabs, sum, diff, c, x;
		logic [63:0] cm, qm, rf, y;
		logic neg;
		out_t o;
		c1 = longint'(a.anchor_one_pos) - longint'(off);
		c2 = longint'(a.anchor_two_pos) - longint'(off);
		r1 = longint'({48'd0, a.range_one});
		r2 = longint'({48'd0, a.range_two});
		dd = c1 - c2;
		dabs = dd < 0 ? -dd : dd;
		sum = r1 + r2;
		diff = r1 > r2 ? r1 - r2 : r2 - r1;
		x = 0;
		y = 0;
		if (dd == 0 && r1 == r2) begin
			o.solve_status = ST_SAME;
		end else if (dabs > sum || dabs < diff) begin
			o.solve_status = ST_NONE;
		end else begin
			c = r2 * r2 - r1 * r1 - dd * dd;
			cm = c < 0 ? -c : c;
			// round to nearest, ties away from zero
			qm = ((cm << FRAC_BITS) + dabs) / (2 * dabs);
			neg = (c < 0) != (dd < 0);
			o.solve_status = (dabs == sum || dabs == diff) ? ST_TANGENT : ST_TWO;
			x = c1 * (64'sd1 <<< FRAC_BITS) + (neg ? -longint'(qm) : longint'(qm));
			if (x > 33554431) x = 33554431;
			if (x < -33554432) x = -33554432;
			rf = r1 << FRAC_BITS;
			if (qm > rf) qm = rf;
			y = root_floor(rf * rf - qm * qm);
			if (y > 64'hFFFFFF) y = 64'hFFFFFF;
		end
		o.pos_x = x[XW-1:0];
		o.pos_y = y[YW-1:0];
		return o;
	endfunction

	assign pending = fix_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			fail_count <= 0;
			fix_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) offset_q <= cfg_data;
			if (start && !busy) fix_q.push_back(solve_fix(req, offset_q));
			if (done) begin
				if (fix_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res);
					fail_count <= fail_count + 1;
				end else begin
					e = fix_q.pop_front();
					if (e.pos_x !== res.pos_x || e.pos_y !== res.pos_y
							|| e.solve_status !== res.solve_status) begin
						$display("%0t: expected x=%h y=%h st=%0d got x=%h y=%h st=%0d",
							$time, e.pos_x, e.pos_y, e.solve_status,
							res.pos_x, res.pos_y, res.solve_status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/two_anchor_position_solver_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module two_anchor_position_solver_tb;
	import tas_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	in_t req = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic signed [15:0] cfg_data = '0;
	logic done;
	out_t res;
	int fail_count;
	int pending;
	int idle_cycles = 0;

	always #1 clk = ~clk;

	two_anchor_position_solver dut (.*);

	two_anchor_position_solver_chk chk (
		.clk, .arst_n, .start, .busy, .req, .cfg_valid, .cfg_ready,
		.cfg_data, .done, .res, .fail_count, .pending
	);

	// watchdog on cycles with no request, result or config write moving
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send(input in_t a);
		start <= 1;
		req <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(0, 2) == 0) begin
			start <= 0;
			gap();
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_offset(input logic signed [15:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic in_t make(input int p1, input int p2, input int r1, input int r2);
		in_t a;
		a.anchor_one_pos = p1[15:0];
		a.anchor_two_pos = p2[15:0];
		a.range_one = r1[15:0];
		a.range_two = r2[15:0];
		return a;
	endfunction

	// mostly intersecting pairs, sometimes tangent, sometimes raw noise
	function automatic in_t rand_item(input int span);
		int p1, p2, d, r1, r2;
		p1 = int'($urandom_range(0, 65535)) - 32768;
		d = int'($urandom_range(0, span)) - span / 2;
		p2 = p1 + d;
		if (p2 > 32767 || p2 < -32768) p2 = p1 - d;
		d = (p1 > p2) ? p1 - p2 : p2 - p1;
		case ($urandom_range(0, 7))
			0: return in_t'({$urandom, $urandom});
			1: begin
				r1 = $urandom_range(0, d);
				r2 = d - r1;
			end
			2: begin
				r1 = $urandom_range(0, 65535 - d);
				r2 = r1 + d;
			end
			default: begin
				r1 = $urandom_range(d / 2, d + span);
				r2 = $urandom_range(d > r1 ? d - r1 : r1 - d, d + r1);
			end
		endcase
		if (r1 > 65535) r1 = 65535;
		if (r2 > 65535) r2 = 65535;
		if ($urandom_range(0, 1)) return make(p1, p2, r1, r2);
		return make(p2, p1, r2, r1);
	endfunction

	initial begin
		logic signed [15:0] offsets[5] = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd620, 16'sd0};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(make(0, 0, 5, 5));
		send(make(0, 0, 3, 7));
		send(make(0, 10, 3, 4));
		send(make(0, 10, 4, 6));
		send(make(0, 10, 2, 12));
		send(make(0, 10, 6, 8));
		send(make(0, 10, 0, 10));
		send(make(0, 3, 65535, 65535));
		send(make(-32768, 32767, 65535, 65535));
		send(make(32767, -32768, 65535, 0));
		send(make(-32768, 32767, 0, 65535));
		send(make(100, 101, 1, 1));
		send(make(5, 4, 65535, 65534));
		send(make(-32768, -32768, 0, 0));
		send(make(32767, 32766, 0, 1));
		send(make(0, 7, 5, 5));
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4) offsets[ph] = 16'($urandom);
			set_offset(offsets[ph]);
			for (int i = 0; i < 320; i++)
				send(rand_item($urandom_range(0, 3) == 0 ? 65535 : 200));
			drain();
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/tas_pkg.sv
sv/tas_front.sv
sv/tas_queue.sv
sv/tas_back.sv
sv/two_anchor_position_solver.sv
tb/sv/two_anchor_position_solver_chk.sv
tb/sv/two_anchor_position_solver_tb.sv
